// ===== rtl/ubxr_pkg.sv =====
// Shared types, codes and constants of the UBX frame receiver.
package ubxr_pkg;

  // Field widths
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int CFG_IDX_W = 8;

  // Frame format
  localparam logic [7:0]  SYNC1_BYTE  = 8'hB5;
  localparam logic [7:0]  SYNC2_BYTE  = 8'h62;
  localparam logic [7:0]  ACK_CLASS   = 8'h05;
  localparam logic [7:0]  ACK_ID      = 8'h01;
  localparam logic [7:0]  NAK_ID      = 8'h00;
  localparam logic [15:0] MAX_PAYLOAD = 16'd128;

  // Default number of payload bytes kept for frame judgement
  localparam int HEAD_KEEP_DEF = 3;

  // Decoupling queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Operation codes of an input transaction
  localparam logic [OP_W-1:0] OP_RX      = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR_ACK = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_AIR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_CLASS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_ID     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_MODEL = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REPLY    = 8'd3;

  // Configuration reset values
  localparam logic [7:0] WATCH_CLASS_RST  = 8'd6;
  localparam logic [7:0] WATCH_ID_RST     = 8'd36;
  localparam logic [7:0] WANTED_MODEL_RST = 8'd6;
  localparam logic [7:0] MIN_REPLY_RST    = 8'd36;

  // Classified command kinds
  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_CLR_ACK,
    KIND_CLR_AIR,
    KIND_NOP
  } kind_t;

  // Parser phases
  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LENL,
    PH_LENH,
    PH_PAYLOAD,
    PH_CKA,
    PH_CKB
  } phase_t;

  // Queue entry: classified command
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              is_sync1;
    logic              is_sync2;
  } entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

  // Configuration write
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
  } cfg_wr_t;

  // Result of one step
  typedef struct packed {
    logic       frame_valid;
    logic [7:0] frame_class;
    logic [7:0] frame_id;
    logic [7:0] frame_len;
    logic       ack_flag;
    logic       nak_flag;
    logic       airborne_flag;
    logic       checksum_error;
    logic       length_error;
  } result_t;

endpackage

// ===== rtl/ubxr_ifs.sv =====
// Channel interfaces of the UBX frame receiver: input, result and configuration.
interface ubxr_in_if;
  logic                         valid;
  logic                         ready;
  logic [ubxr_pkg::OP_W-1:0]    operation;
  logic [ubxr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink   (input valid, operation, rx_byte, output ready);
endinterface

interface ubxr_out_if;
  logic       valid;
  logic       ready;
  logic       frame_valid;
  logic [7:0] frame_class;
  logic [7:0] frame_id;
  logic [7:0] frame_len;
  logic       ack_flag;
  logic       nak_flag;
  logic       airborne_flag;
  logic       checksum_error;
  logic       length_error;

  modport source (output valid, frame_valid, frame_class, frame_id, frame_len, ack_flag,
                  nak_flag, airborne_flag, checksum_error, length_error, input ready);
  modport sink   (input valid, frame_valid, frame_class, frame_id, frame_len, ack_flag,
                  nak_flag, airborne_flag, checksum_error, length_error, output ready);
endinterface

interface ubxr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ubxr_pkg::CFG_IDX_W-1:0]  index;
  logic [ubxr_pkg::BYTE_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ubxr_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
module ubxr_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ubxr_pkg::OP_W-1:0]    in_operation,
  input  logic [ubxr_pkg::BYTE_W-1:0]  in_rx_byte,
  output ubxr_pkg::qhead_t             q_head,
  input  logic                         q_pop
);

  ubxr_pkg::entry_t                 mem_r [ubxr_pkg::QDEPTH];
  logic [ubxr_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ubxr_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ubxr_pkg::QCNT_W-1:0]      count_r, count_nxt;
  ubxr_pkg::entry_t                 cls;
  logic                             push;
  logic                             pop;

  // Classify the incoming command
  always_comb begin
    cls.data     = in_rx_byte;
    cls.is_sync1 = (in_rx_byte == ubxr_pkg::SYNC1_BYTE);
    cls.is_sync2 = (in_rx_byte == ubxr_pkg::SYNC2_BYTE);
    unique case (in_operation)
      ubxr_pkg::OP_RX:      cls.kind = ubxr_pkg::KIND_BYTE;
      ubxr_pkg::OP_CLR_ACK: cls.kind = ubxr_pkg::KIND_CLR_ACK;
      ubxr_pkg::OP_CLR_AIR: cls.kind = ubxr_pkg::KIND_CLR_AIR;
      default:              cls.kind = ubxr_pkg::KIND_NOP;
    endcase
  end

  assign in_ready = (count_r != ubxr_pkg::QCNT_W'(ubxr_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (count_r != '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ubxr_pkg::QPTR_W'(ubxr_pkg::QDEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ubxr_pkg::QPTR_W'(ubxr_pkg::QDEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + ubxr_pkg::QCNT_W'(push) - ubxr_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ubxr_pkg::QCNT_W'(ubxr_pkg::QDEPTH))
    else $error("queue occupancy above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy missed a push");
`endif

endmodule

// ===== rtl/ubxr_back.sv =====
// Back end: UBX parser, Fletcher checks, frame judgement and result register.
module ubxr_back #(
  parameter int HEAD_KEEP = ubxr_pkg::HEAD_KEEP_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ubxr_pkg::qhead_t     q_head,
  output logic                 q_pop,
  input  ubxr_pkg::cfg_wr_t    cfg_wr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ubxr_pkg::result_t    out_res
);

  ubxr_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]         cur_class_r, cur_class_nxt;
  logic [7:0]         cur_id_r, cur_id_nxt;
  logic [15:0]        cur_len_r, cur_len_nxt;
  logic [7:0]         byte_index_r, byte_index_nxt;
  logic [7:0]         sum_a_r, sum_a_nxt;
  logic [7:0]         sum_b_r, sum_b_nxt;
  logic [7:0]         head_r [HEAD_KEEP];
  logic               head_we;
  logic               ack_r, ack_nxt;
  logic               nak_r, nak_nxt;
  logic               air_r, air_nxt;
  logic [7:0]         watch_class_r, watch_id_r, wanted_model_r, min_reply_r;
  logic               out_valid_r;
  ubxr_pkg::result_t  res_r, res_nxt;
  logic               load;
  logic               is_byte;
  logic [7:0]         c;
  logic [7:0]         idx_inc;
  logic               cka_ok, ckb_ok, len_big, names_watched;

  // Take a queued command when the result slot is free or being drained
  assign load    = q_head.valid && (!out_valid_r || out_ready);
  assign q_pop   = load;
  assign is_byte = (q_head.entry.kind == ubxr_pkg::KIND_BYTE);
  assign c       = q_head.entry.data;

  assign idx_inc      = (byte_index_r != 8'hFF) ? byte_index_r + 8'd1 : byte_index_r;
  assign cka_ok       = (c == sum_a_r);
  assign ckb_ok       = (c == sum_b_r);
  assign len_big      = ({c, cur_len_r[7:0]} > ubxr_pkg::MAX_PAYLOAD);
  assign names_watched = (head_r[0] == watch_class_r) && (head_r[1] == watch_id_r);

  // Next parser phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_byte) begin
      unique case (phase_r)
        ubxr_pkg::PH_SYNC1:
          if (q_head.entry.is_sync1) phase_nxt = ubxr_pkg::PH_SYNC2;
        ubxr_pkg::PH_SYNC2:
          phase_nxt = q_head.entry.is_sync2 ? ubxr_pkg::PH_CLASS : ubxr_pkg::PH_SYNC1;
        ubxr_pkg::PH_CLASS: phase_nxt = ubxr_pkg::PH_ID;
        ubxr_pkg::PH_ID:    phase_nxt = ubxr_pkg::PH_LENL;
        ubxr_pkg::PH_LENL:  phase_nxt = ubxr_pkg::PH_LENH;
        ubxr_pkg::PH_LENH: begin
          if (len_big) begin
            phase_nxt = ubxr_pkg::PH_SYNC1;
          end else if ({c, cur_len_r[7:0]} == 16'd0) begin
            phase_nxt = ubxr_pkg::PH_CKA;
          end else begin
            phase_nxt = ubxr_pkg::PH_PAYLOAD;
          end
        end
        ubxr_pkg::PH_PAYLOAD:
          if ({8'h00, idx_inc} >= cur_len_r) phase_nxt = ubxr_pkg::PH_CKA;
        ubxr_pkg::PH_CKA:
          phase_nxt = cka_ok ? ubxr_pkg::PH_CKB : ubxr_pkg::PH_SYNC1;
        ubxr_pkg::PH_CKB:   phase_nxt = ubxr_pkg::PH_SYNC1;
        default:            phase_nxt = ubxr_pkg::PH_SYNC1;
      endcase
    end
  end

  // Datapath, flags and result of this step
  always_comb begin
    cur_class_nxt  = cur_class_r;
    cur_id_nxt     = cur_id_r;
    cur_len_nxt    = cur_len_r;
    byte_index_nxt = byte_index_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    head_we        = 1'b0;
    ack_nxt        = ack_r;
    nak_nxt        = nak_r;
    air_nxt        = air_r;
    res_nxt        = '0;

    unique case (q_head.entry.kind)
      ubxr_pkg::KIND_CLR_ACK: begin
        ack_nxt = 1'b0;
        nak_nxt = 1'b0;
      end
      ubxr_pkg::KIND_CLR_AIR: air_nxt = 1'b0;
      ubxr_pkg::KIND_NOP: ;
      ubxr_pkg::KIND_BYTE: begin
        unique case (phase_r)
          ubxr_pkg::PH_CLASS: begin
            cur_class_nxt = c;
            sum_a_nxt     = c;
            sum_b_nxt     = c;
          end
          ubxr_pkg::PH_ID: begin
            cur_id_nxt = c;
            sum_a_nxt  = sum_a_r + c;
            sum_b_nxt  = sum_b_r + sum_a_nxt;
          end
          ubxr_pkg::PH_LENL: begin
            cur_len_nxt = {8'h00, c};
            sum_a_nxt   = sum_a_r + c;
            sum_b_nxt   = sum_b_r + sum_a_nxt;
          end
          ubxr_pkg::PH_LENH: begin
            cur_len_nxt          = {c, cur_len_r[7:0]};
            sum_a_nxt            = sum_a_r + c;
            sum_b_nxt            = sum_b_r + sum_a_nxt;
            byte_index_nxt       = 8'd0;
            res_nxt.length_error = len_big;
          end
          ubxr_pkg::PH_PAYLOAD: begin
            sum_a_nxt      = sum_a_r + c;
            sum_b_nxt      = sum_b_r + sum_a_nxt;
            head_we        = 1'b1;
            byte_index_nxt = idx_inc;
          end
          ubxr_pkg::PH_CKA: res_nxt.checksum_error = !cka_ok;
          ubxr_pkg::PH_CKB: begin
            res_nxt.checksum_error = !ckb_ok;
            res_nxt.frame_valid    = ckb_ok;
            // Judge the good frame: ACK, then NAK, then watched reply
            if (ckb_ok) begin
              priority if (cur_class_r == ubxr_pkg::ACK_CLASS &&
                           cur_id_r == ubxr_pkg::ACK_ID) begin
                if (names_watched) ack_nxt = 1'b1;
              end else if (cur_class_r == ubxr_pkg::ACK_CLASS &&
                           cur_id_r == ubxr_pkg::NAK_ID) begin
                if (names_watched) nak_nxt = 1'b1;
              end else if (cur_class_r == watch_class_r && cur_id_r == watch_id_r &&
                           cur_len_r >= {8'h00, min_reply_r}) begin
                if (head_r[2] == wanted_model_r) air_nxt = 1'b1;
              end else begin
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    res_nxt.frame_class   = cur_class_nxt;
    res_nxt.frame_id      = cur_id_nxt;
    res_nxt.frame_len     = (cur_len_nxt[15:8] != 8'h00) ? 8'hFF : cur_len_nxt[7:0];
    res_nxt.ack_flag      = ack_nxt;
    res_nxt.nak_flag      = nak_nxt;
    res_nxt.airborne_flag = air_nxt;
  end

  // Parser and flag state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ubxr_pkg::PH_SYNC1;
      cur_class_r  <= '0;
      cur_id_r     <= '0;
      cur_len_r    <= '0;
      byte_index_r <= '0;
      sum_a_r      <= '0;
      sum_b_r      <= '0;
      ack_r        <= 1'b0;
      nak_r        <= 1'b0;
      air_r        <= 1'b0;
    end else if (load) begin
      phase_r      <= phase_nxt;
      cur_class_r  <= cur_class_nxt;
      cur_id_r     <= cur_id_nxt;
      cur_len_r    <= cur_len_nxt;
      byte_index_r <= byte_index_nxt;
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      ack_r        <= ack_nxt;
      nak_r        <= nak_nxt;
      air_r        <= air_nxt;
    end
  end

  // Kept payload bytes, cleared at reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < HEAD_KEEP; i++) begin
      if (!rst_n) begin
        head_r[i] <= '0;
      end else if (load && head_we && byte_index_r == 8'(i)) begin
        head_r[i] <= c;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_class_r  <= ubxr_pkg::WATCH_CLASS_RST;
      watch_id_r     <= ubxr_pkg::WATCH_ID_RST;
      wanted_model_r <= ubxr_pkg::WANTED_MODEL_RST;
      min_reply_r    <= ubxr_pkg::MIN_REPLY_RST;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        ubxr_pkg::CFG_WATCH_CLASS:  watch_class_r  <= cfg_wr.data;
        ubxr_pkg::CFG_WATCH_ID:     watch_id_r     <= cfg_wr.data;
        ubxr_pkg::CFG_WANTED_MODEL: wanted_model_r <= cfg_wr.data;
        ubxr_pkg::CFG_MIN_REPLY:    min_reply_r    <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

`ifndef SYNTH
  a_valid_not_err: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !(res_r.frame_valid && res_r.checksum_error))
    else $error("frame reported both good and bad");

  a_len_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_nxt.length_error) |-> (phase_r == ubxr_pkg::PH_LENH))
    else $error("length error outside high length byte");

  a_valid_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_nxt.frame_valid) |=> (phase_r == ubxr_pkg::PH_SYNC1))
    else $error("parser not back to sync hunt after good frame");
`endif

endmodule

// ===== rtl/ubx_frame_receiver.sv =====
// Top level of the UBX frame receiver: front end, command queue and parser back end.
// Takes one command per clock (a received byte or a flag clear) while the queue has room
// and returns exactly one result transaction per command. A command passes a classifying
// front end into a two-entry queue, and the parser back end retires one queued command per
// clock into a result register while the result side does not stall; a command is thus
// registered first in the queue and then, as its result, in the result register.
// Throughput is one command per clock when nothing stalls, set by the single-cycle parser
// step (one Fletcher add pair and the check byte compares). Configuration writes are taken
// every clock and must only be issued while no command is in flight.
module ubx_frame_receiver #(
  parameter int HEAD_KEEP = ubxr_pkg::HEAD_KEEP_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ubxr_in_if.sink      in_ch,
  ubxr_out_if.source   out_ch,
  ubxr_cfg_if.sink     cfg_ch
);

  ubxr_pkg::qhead_t   q_head;
  logic               q_pop;
  ubxr_pkg::cfg_wr_t  cfg_wr;
  ubxr_pkg::result_t  res;

  // Configuration port never stalls
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.we    = cfg_ch.valid;
  assign cfg_wr.index = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  ubxr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .in_rx_byte   (in_ch.rx_byte),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  ubxr_back #(
    .HEAD_KEEP (HEAD_KEEP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_wr    (cfg_wr),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  // Drive the result channel payload
  assign out_ch.frame_valid    = res.frame_valid;
  assign out_ch.frame_class    = res.frame_class;
  assign out_ch.frame_id       = res.frame_id;
  assign out_ch.frame_len      = res.frame_len;
  assign out_ch.ack_flag       = res.ack_flag;
  assign out_ch.nak_flag       = res.nak_flag;
  assign out_ch.airborne_flag  = res.airborne_flag;
  assign out_ch.checksum_error = res.checksum_error;
  assign out_ch.length_error   = res.length_error;

endmodule
